/* src/kmbp_pkg.sv */
// Package for the keyed mixing byte generator: types, constants, mixing functions.
// No dependencies.
package kmbp_pkg;

    localparam logic [31:0] LCG_MUL = 32'd69069;

    // Controller commands to the datapath
    typedef struct packed {
        logic load_seed;   // w <= seed
        logic lcg_step;    // w <= w*mul+1, store word
        logic sched_step;  // schedule one word
        logic sched_fin;   // compute null indices
        logic round;       // one mixing round
        logic clr_round;   // reset round counters
    } t_cmd;

    typedef struct packed {
        logic [3:0] word_idx;
        logic [1:0] round_i;
        logic [1:0] round_n;
    } t_sts;

    function automatic logic [31:0] mix4(input logic [31:0] x);
        return (x + (x << 4)) ^ (x >> 5);
    endfunction

    function automatic logic [31:0] mix6(input logic [31:0] x);
        return (x + (x << 6)) ^ (x >> 9);
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
        return (x >> s) | (x << (6'd32 - {1'b0, s}));
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        return (x << s) | (x >> (6'd32 - {1'b0, s}));
    endfunction

    // x mod 3 via digit sums (mod 4 == 1)
    function automatic logic [1:0] mod3(input logic [31:0] x);
        logic [5:0] s;
        logic [3:0] t;
        logic [2:0] u;
        s = '0;
        for (int k = 0; k < 16; k++) s = s + 6'(x[2*k +: 2]);
        t = 4'(s[1:0]) + 4'(s[3:2]) + 4'(s[5:4]);
        u = 3'(t[1:0]) + 3'(t[3:2]);
        return (u >= 3'd6) ? 2'(u - 3'd6) : (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
    endfunction

    // x mod 31 via 5-bit digit sums (mod 32 == 1); top digit is two bits
    function automatic logic [4:0] mod31(input logic [31:0] x);
        logic [8:0] s;
        logic [5:0] t;
        s = '0;
        for (int k = 0; k < 6; k++) s = s + 9'(x[5*k +: 5]);
        s = s + 9'(x[31:30]);
        t = 6'(s[4:0]) + 6'(s[8:5]);
        t = 6'(t[4:0]) + 6'(t[5]);
        return (t >= 6'd31) ? 5'(t - 6'd31) : t[4:0];
    endfunction

endpackage

/* src/kmbp_ctrl.sv */
// Controller FSM for the keyed mixing byte generator.
// Depends on kmbp_pkg.
module kmbp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic          i_restart,
    output logic          o_valid,
    input  logic          i_stall,
    input  kmbp_pkg::t_sts i_sts,
    output kmbp_pkg::t_cmd o_cmd
);
    import kmbp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LCG   = 6'b000010,
        S_SCHED = 6'b000100,
        S_FIN   = 6'b001000,
        S_MIX   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.clr_round = 1'b1;
                    if (i_restart) begin
                        o_cmd.load_seed = 1'b1;
                        n_state = S_LCG;
                    end else begin
                        n_state = S_MIX;
                    end
                end
            end
            S_LCG: begin
                o_cmd.lcg_step = 1'b1;
                if (i_sts.word_idx == 4'd11) n_state = S_SCHED;
            end
            S_SCHED: begin
                o_cmd.sched_step = 1'b1;
                if (i_sts.word_idx == 4'd7) n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.sched_fin = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                o_cmd.round = 1'b1;
                if (i_sts.round_i == 2'd3 && i_sts.round_n == 2'd3) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule

/* src/kmbp_dp.sv */
// Datapath: seed expansion, key schedule, and round-per-cycle mixing.
// Depends on kmbp_pkg.
module kmbp_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [31:0]   i_seed,
    input  kmbp_pkg::t_cmd i_cmd,
    output kmbp_pkg::t_sts o_sts,
    output logic [7:0]    o_random_byte
);
    import kmbp_pkg::*;

    logic [31:0] r_w [12];     // expanded words
    logic [31:0] r_x;          // LCG value
    logic [3:0]  r_idx;        // word counter
    logic [31:0] r_acc_a, r_acc_b, r_acc_c;
    logic [31:0] r_v [4];
    logic [31:0] r_kl [4];
    logic [31:0] r_kh [4];
    logic [1:0]  r_ba [4];
    logic [1:0]  r_bb [4];
    logic [4:0]  r_rb [8];
    logic [1:0]  r_nul [3];
    logic [1:0]  r_ia, r_ib, r_i, r_n;
    logic [31:0] r_prod;       // w*(i+1) product for acc_c (registered)

    assign o_sts.word_idx = r_idx;
    assign o_sts.round_i  = r_i;
    assign o_sts.round_n  = r_n;
    assign o_random_byte  = r_v[0][7:0];

    // schedule word view
    logic [2:0]  s_i;
    logic [31:0] s_w, s_m4, s_wk, s_m4k;
    logic [4:0]  s_rot;
    assign s_i   = r_idx[2:0];
    assign s_w   = r_w[{1'b0, s_i}];
    assign s_m4  = mix4(s_w);
    assign s_wk  = r_w[4'd4 + {1'b0, s_i[1:0]}];
    assign s_m4k = mix4(s_wk);
    assign s_rot = mod31(rotl(s_w ^ 32'(s_i + 3'd1), 5'd7 - 5'(s_i) + 5'd1)) + 5'd1;

    // round logic
    logic [31:0] k1, k2, k3, k4, m0, m1, a0, a1, b2, b3;
    logic [4:0]  r1, r2;
    logic [2:0]  rs;
    assign k1 = r_kl[r_ia];
    assign k2 = r_kl[r_ia + 2'd1];
    assign k3 = r_kh[r_ib];
    assign k4 = r_kh[r_ib + 2'd1];
    assign rs = 3'(r_ia) + 3'(r_ib);
    assign r1 = r_rb[rs];
    assign r2 = r_rb[rs + 3'd1];
    assign m0 = mix6(r_v[1]);
    assign a0 = (r_ia == r_nul[0]) ? r_v[0] + r_v[3] + rotr(m0, r1) + k1
                                   : r_v[0] + r_v[3] + rotr(m0 + k1, r1);
    assign m1 = mix6(a0);
    assign a1 = (r_ib == r_nul[1]) ? r_v[1] + r_v[2] + rotr(m1, r2) + k2
                                   : r_v[1] + r_v[2] + rotr(m1 + k2, r2);
    assign b2 = (r_i == r_nul[2]) ? r_v[2] + (mix4(a0) + k3) : r_v[2] ^ (mix4(a0) + k3);
    assign b3 = (r_i == r_nul[2]) ? r_v[3] + (mix4(a1) + k4) : r_v[3] ^ (mix4(a1) + k4);

    logic [31:0] fa, fb, fc;
    assign fa = r_acc_a ^ (r_acc_a >> 16);
    assign fb = r_acc_b ^ (r_acc_b >> 16);
    assign fc = r_acc_c + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_v[k] <= '0; r_kl[k] <= '0; r_kh[k] <= '0;
                r_ba[k] <= '0; r_bb[k] <= '0;
            end
            for (int k = 0; k < 8; k++) r_rb[k] <= 5'd1;
            for (int k = 0; k < 3; k++) r_nul[k] <= '0;
            r_idx <= '0; r_i <= '0; r_n <= '0; r_ia <= '0; r_ib <= '0;
        end else begin
            if (i_cmd.clr_round) begin
                r_i  <= '0;
                r_n  <= '0;
                r_ia <= r_ba[0];
                r_ib <= r_bb[0];
            end
            if (i_cmd.load_seed) begin
                r_x   <= i_seed;
                r_idx <= '0;
            end
            // seed expansion, one word a cycle
            if (i_cmd.lcg_step) begin
                r_w[r_idx] <= r_x;
                r_x        <= r_x * LCG_MUL + 32'd1;
                r_idx      <= (r_idx == 4'd11) ? 4'd0 : r_idx + 4'd1;
                r_acc_a <= '0; r_acc_b <= '0; r_acc_c <= '0;
                r_prod <= '0;
            end
            // key schedule, one word per cycle; tri products fed from the previous accumulator
            if (i_cmd.sched_step) begin
                r_rb[s_i] <= s_rot;
                if (!s_i[2]) begin
                    r_ba[s_i[1:0]] <= mod3(rotr(s_m4, 5'(s_i) + 5'd1));
                    r_bb[2'd3 - s_i[1:0]] <= mod3(rotl(s_m4k, 5'(s_i) + 5'd5));
                    // triangular accumulators: acc = (acc*(acc+1))>>1 + w
                    r_acc_a <= 32'((r_acc_a * (r_acc_a + 32'd1)) >> 1) + s_w;
                    r_acc_b <= 32'((r_acc_b * (r_acc_b + 32'd1)) >> 1) + s_wk;
                end
                r_acc_c <= fc;
                r_prod  <= s_w * 32'(4'(s_i) + 4'd1);
                r_idx   <= r_idx + 4'd1;
                r_kl[s_i[1:0]] <= r_w[{2'b00, s_i[1:0]}];
                r_kh[s_i[1:0]] <= r_w[4'd4 + {2'b00, s_i[1:0]}];
                r_v[s_i[1:0]]  <= r_w[4'd8 + {2'b00, s_i[1:0]}];
            end
            if (i_cmd.sched_fin) begin
                r_nul[0] <= fa[1:0];
                r_nul[1] <= fb[1:0];
                r_nul[2] <= fc[1:0] ^ fc[17:16];
                r_ia <= r_ba[0];
                r_ib <= r_bb[0];
                r_i <= '0; r_n <= '0;
            end
            // one mixing round per cycle
            if (i_cmd.round) begin
                r_v[0] <= b2; r_v[1] <= b3; r_v[2] <= a0; r_v[3] <= a1;
                r_i <= r_i + 2'd1;
                if (r_i == 2'd3) begin
                    r_n  <= r_n + 2'd1;
                    r_ia <= r_ba[r_n + 2'd1];
                    r_ib <= r_bb[r_n + 2'd1];
                end else begin
                    r_ia <= (r_ia == 2'd2) ? 2'd0 : r_ia + 2'd1;
                    r_ib <= (r_ib == 2'd2) ? 2'd0 : r_ib + 2'd1;
                end
            end
        end
    end
endmodule

/* src/keyed_mixing_byte_prng_top.sv */
// Top level of the keyed mixing byte generator.
// Depends on kmbp_pkg, kmbp_ctrl, kmbp_dp.
//
//  channel | signals                          | dir
//  in      | i_valid, o_stall, i_restart      | item in
//  out     | o_valid, i_stall, o_random_byte  | item out
//  cfg     | i_cfg_we, i_cfg_data             | seed write
//
// Without restart an item takes an accept step, 16 rounds (one round a cycle in
// the mixing datapath) and an output step. Restart adds 12 seed expansion steps,
// 8 schedule steps, 1 final step. Synchronous active-low reset clears all but r_w,
// r_x, r_acc_*, r_prod. The result is held while i_stall is high; no new item then.
module keyed_mixing_byte_prng_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_restart,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_random_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data
);
    import kmbp_pkg::*;

    logic [31:0] r_seed;
    t_cmd cmd;
    t_sts sts;

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_seed <= '0;
        else if (i_cfg_we) r_seed <= i_cfg_data;
    end

    kmbp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_restart,
        .o_valid, .i_stall, .i_sts(sts), .o_cmd(cmd)
    );

    kmbp_dp u_dp (
        .i_clk, .i_rst_n, .i_seed(r_seed), .i_cmd(cmd), .o_sts(sts),
        .o_random_byte
    );
endmodule
